// ----- rtl/cpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared codes and constants for the collision pair tester.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// Test kinds carried on func.
	localparam logic [1:0] FUNC_SPH_SPH = 2'd0;
	localparam logic [1:0] FUNC_BOX_BOX = 2'd1;
	localparam logic [1:0] FUNC_BOX_SPH = 2'd2;

	// Contact classes.
	localparam logic [1:0] CLS_OUTSIDE    = 2'd0;
	localparam logic [1:0] CLS_INTERSECTS = 2'd1;
	localparam logic [1:0] CLS_CONTAINS   = 2'd2;

	// Saturation limits of the result fields.
	localparam int NORM_LO = -65536;
	localparam int NORM_HI = 65535;
	localparam int SEP_LO  = -65536;
	localparam int SEP_HI  = 131071;

	// Field widths.
	localparam int FIELD_W  = 48;
	localparam int RADIUS_W = 16;
	localparam int NORM_W   = 17;
	localparam int SEP_W    = 18;

	// Kind and class of a beat as it travels down the pipeline.
	typedef struct packed {
		logic [1:0] func;
		logic [1:0] cls;
	} cpt_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/cpt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_front
// Three pipeline stages: differences and clamps, squares and box gap,
// squared-distance sum with classification and normal selection.
// ----------------------------------------------------------------------------
module cpt_front #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic [1:0]                         func,
	input  wire logic [cpt_pkg::FIELD_W-1:0]        a_low_xyz,
	input  wire logic [cpt_pkg::FIELD_W-1:0]        a_high_xyz,
	input  wire logic [cpt_pkg::FIELD_W-1:0]        b_low_xyz,
	input  wire logic [cpt_pkg::FIELD_W-1:0]        b_high_xyz,
	input  wire logic [cpt_pkg::RADIUS_W-1:0]       a_radius,
	input  wire logic [cpt_pkg::RADIUS_W-1:0]       b_radius,
	output logic                                    out_valid,
	output cpt_pkg::cpt_ctl_t                       out_ctl,
	output logic [2*COORD_BITS+3:0]                 out_msq,
	output logic [3*(COORD_BITS+1)-1:0]             out_norm,
	output logic [COORD_BITS:0]                     out_gap,
	output logic [cpt_pkg::FIELD_W-1:0]             out_closest
);
	import cpt_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	localparam int M_W   = 2 * CB + 4;
	localparam int R_W   = RADIUS_W + 1;
	localparam int CMP_W = (M_W > 2 * R_W) ? M_W : 2 * R_W;

	logic [63:0] al64, ah64, bl64, bh64;
	logic signed [CB-1:0] al [3];
	logic signed [CB-1:0] ah [3];
	logic signed [CB-1:0] bl [3];
	logic signed [CB-1:0] bh [3];

	assign al64 = {16'd0, a_low_xyz};
	assign ah64 = {16'd0, a_high_xyz};
	assign bl64 = {16'd0, b_low_xyz};
	assign bh64 = {16'd0, b_high_xyz};

	// Unpack the three coordinates of each corner.
	for (genvar i = 0; i < 3; i++) begin : g_axis
		assign al[i] = $signed(al64[i*CB +: CB]);
		assign ah[i] = $signed(ah64[i*CB +: CB]);
		assign bl[i] = $signed(bl64[i*CB +: CB]);
		assign bh[i] = $signed(bh64[i*CB +: CB]);
	end

	// Stage 1 registers.
	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] gx_s1 [3];
	logic signed [CB-1:0] c_s1 [3];
	logic signed [CB-1:0] al_s1 [3];
	logic signed [CB-1:0] ah_s1 [3];
	logic signed [CB-1:0] p_s1 [3];
	logic signed [DW-1:0] v_s1 [3];
	logic signed [R_W-1:0] rlo_s1;
	logic [R_W-1:0]       rhi_s1;

	logic signed [DW-1:0] d_n [3];
	logic signed [DW-1:0] gx_n [3];
	logic signed [CB-1:0] c_n [3];
	logic signed [CB-1:0] p_n [3];
	logic signed [DW-1:0] v_n [3];

	// Stage 1 logic: center offsets, per-axis gaps, box B center, clamp.
	always_comb begin
		logic signed [DW-1:0] g1, g2, sum;
		logic signed [CB-1:0] t;
		for (int i = 0; i < 3; i++) begin
			d_n[i]  = DW'(bl[i]) - DW'(al[i]);
			g1      = DW'(bl[i]) - DW'(ah[i]);
			g2      = DW'(al[i]) - DW'(bh[i]);
			gx_n[i] = (g1 > g2) ? g1 : g2;
			sum     = DW'(bl[i]) + DW'(bh[i]);
			c_n[i]  = CB'(sum >>> 1);
			t       = (bl[i] < al[i]) ? al[i] : bl[i];
			p_n[i]  = (t > ah[i]) ? ah[i] : t;
			v_n[i]  = DW'(p_n[i]) - DW'(bl[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		for (int i = 0; i < 3; i++) begin
			d_s1[i]  <= d_n[i];
			gx_s1[i] <= gx_n[i];
			c_s1[i]  <= c_n[i];
			al_s1[i] <= al[i];
			ah_s1[i] <= ah[i];
			p_s1[i]  <= p_n[i];
			v_s1[i]  <= v_n[i];
		end
		rlo_s1 <= $signed({1'b0, a_radius}) - $signed({1'b0, b_radius});
		rhi_s1 <= (func == FUNC_SPH_SPH) ? ({1'b0, a_radius} + {1'b0, b_radius})
		                                 : {1'b0, b_radius};
	end

	// Stage 2 registers.
	logic                 valid_s2;
	logic [1:0]           func_s2;
	logic [2*DW-1:0]      sq_s2 [3];
	logic signed [DW-1:0] w_s2 [3];
	logic signed [DW-1:0] nb_s2 [3];
	logic signed [CB-1:0] p_s2 [3];
	logic signed [DW-1:0] g_s2;
	logic [2*R_W-1:0]     sqlo_s2, sqhi_s2;

	logic signed [DW-1:0]   w_n [3];
	logic signed [DW-1:0]   nb_n [3];
	logic signed [2*DW-1:0] sq_n [3];
	logic signed [DW-1:0]   g_n;
	logic signed [2*R_W-1:0] sqlo_n;

	// Stage 2 logic: squares, largest gap, box B center against box A.
	always_comb begin
		logic signed [CB-1:0] t, cc;
		for (int i = 0; i < 3; i++) begin
			w_n[i]  = (func_s1 == FUNC_SPH_SPH) ? d_s1[i] : v_s1[i];
			sq_n[i] = w_n[i] * w_n[i];
			t       = (c_s1[i] < al_s1[i]) ? al_s1[i] : c_s1[i];
			cc      = (t > ah_s1[i]) ? ah_s1[i] : t;
			nb_n[i] = DW'(c_s1[i]) - DW'(cc);
		end
		g_n = gx_s1[0];
		if (gx_s1[1] > g_n) begin
			g_n = gx_s1[1];
		end
		if (gx_s1[2] > g_n) begin
			g_n = gx_s1[2];
		end
		sqlo_n = rlo_s1 * rlo_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= sq_n[i];
			w_s2[i]  <= w_n[i];
			nb_s2[i] <= nb_n[i];
			p_s2[i]  <= p_s1[i];
		end
		g_s2    <= g_n;
		sqlo_s2 <= sqlo_n;
		sqhi_s2 <= rhi_s1 * rhi_s1;
	end

	// Stage 3 logic: squared distance, class and normal per test kind.
	logic [M_W-1:0]       m_n;
	logic [CMP_W-1:0]     m_c, lo_c, hi_c;
	logic [1:0]           cls_n;
	logic signed [DW-1:0] nrm_n [3];
	logic [63:0]          clo_n;

	always_comb begin
		m_n  = M_W'(sq_s2[0]) + M_W'(sq_s2[1]) + M_W'(sq_s2[2]);
		m_c  = CMP_W'(m_n);
		lo_c = CMP_W'(sqlo_s2);
		hi_c = CMP_W'(sqhi_s2);
		cls_n = CLS_OUTSIDE;
		clo_n = '0;
		for (int i = 0; i < 3; i++) begin
			nrm_n[i] = '0;
		end
		case (func_s2)
			FUNC_SPH_SPH: begin
				if (m_c < lo_c) begin
					cls_n = CLS_CONTAINS;
				end else if (m_c <= hi_c) begin
					cls_n = CLS_INTERSECTS;
					for (int i = 0; i < 3; i++) begin
						nrm_n[i] = w_s2[i];
					end
				end
			end
			FUNC_BOX_BOX: begin
				if (g_s2 <= 0) begin
					cls_n = CLS_INTERSECTS;
					for (int i = 0; i < 3; i++) begin
						nrm_n[i] = nb_s2[i];
					end
				end
			end
			FUNC_BOX_SPH: begin
				cls_n = (m_c <= hi_c) ? CLS_INTERSECTS : CLS_OUTSIDE;
				for (int i = 0; i < 3; i++) begin
					nrm_n[i] = w_s2[i];
					clo_n[i*CB +: CB] = p_s2[i];
				end
			end
			default: begin
				cls_n = CLS_OUTSIDE;
			end
		endcase
	end

	logic                 valid_s3;
	cpt_ctl_t             ctl_s3;
	logic [M_W-1:0]       msq_s3;
	logic [3*DW-1:0]      norm_s3;
	logic [DW-1:0]        gap_s3;
	logic [FIELD_W-1:0]   clo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3.func <= func_s2;
		ctl_s3.cls  <= cls_n;
		msq_s3      <= m_n;
		norm_s3     <= {nrm_n[2], nrm_n[1], nrm_n[0]};
		gap_s3      <= g_s2;
		clo_s3      <= clo_n[FIELD_W-1:0];
	end

	assign out_valid   = valid_s3;
	assign out_ctl     = ctl_s3;
	assign out_msq     = msq_s3;
	assign out_norm    = norm_s3;
	assign out_gap     = gap_s3;
	assign out_closest = clo_s3;

endmodule
`default_nettype wire

// ----- rtl/cpt_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_isqrt
// Pipelined integer square root, rounded down, one root bit per stage.
// Side data travels alongside with the valid bit.
// ----------------------------------------------------------------------------
module cpt_isqrt #(
	parameter int RAD_W  = 36,
	parameter int SIDE_W = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [RAD_W-1:0]     rad,
	input  wire logic [SIDE_W-1:0]    side_in,
	output logic                      out_valid,
	output logic [RAD_W/2-1:0]        root,
	output logic [SIDE_W-1:0]         side_out
);
	localparam int R  = RAD_W / 2;
	localparam int RW = R + 2;

	logic              vld_sn  [R+1];
	logic [RAD_W-1:0]  rad_sn  [R+1];
	logic [RW-1:0]     rem_sn  [R+1];
	logic [R-1:0]      root_sn [R+1];
	logic [SIDE_W-1:0] side_sn [R+1];

	assign vld_sn[0]  = in_valid;
	assign rad_sn[0]  = rad;
	assign rem_sn[0]  = '0;
	assign root_sn[0] = '0;
	assign side_sn[0] = side_in;

	// Each stage brings down two radicand bits and decides one root bit.
	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [RW:0] rem_in, trial;

		assign rem_in = {rem_sn[k][RW-2:0], rad_sn[k][RAD_W-1-2*k -: 2]};
		assign trial  = {1'b0, root_sn[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_sn[k+1]  <= rad_sn[k];
			side_sn[k+1] <= side_sn[k];
			if (rem_in >= trial) begin
				rem_sn[k+1]  <= RW'(rem_in - trial);
				root_sn[k+1] <= {root_sn[k][R-2:0], 1'b1};
			end else begin
				rem_sn[k+1]  <= RW'(rem_in);
				root_sn[k+1] <= {root_sn[k][R-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_sn[R];
	assign root      = root_sn[R];
	assign side_out  = side_sn[R];

endmodule
`default_nettype wire

// ----- rtl/collision_pair_tester.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// collision_pair_tester
// Sphere-sphere, box-box and box-sphere pair tests on Q8.8 coordinates.
//
// Channel   Ports                                           Handshake
// input     func, a/b_low_xyz, a/b_high_xyz, a/b_radius     start, busy
// result    contact_class, normal_x/y/z, separation,        done
//           closest_xyz
//
// One beat enters per clock; busy stays low. A beat passes three front
// stages, one stage per root bit of the square root (COORD_BITS + 2)
// and the output register. Reset clears only the valid bits. The receiver
// takes every result in the cycle that done is high.
// ----------------------------------------------------------------------------
module collision_pair_tester #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    func,
	input  wire logic [cpt_pkg::FIELD_W-1:0]   a_low_xyz,
	input  wire logic [cpt_pkg::FIELD_W-1:0]   a_high_xyz,
	input  wire logic [cpt_pkg::FIELD_W-1:0]   b_low_xyz,
	input  wire logic [cpt_pkg::FIELD_W-1:0]   b_high_xyz,
	input  wire logic [cpt_pkg::RADIUS_W-1:0]  a_radius,
	input  wire logic [cpt_pkg::RADIUS_W-1:0]  b_radius,
	output logic                               done,
	output logic [1:0]                         contact_class,
	output logic signed [cpt_pkg::NORM_W-1:0]  normal_x,
	output logic signed [cpt_pkg::NORM_W-1:0]  normal_y,
	output logic signed [cpt_pkg::NORM_W-1:0]  normal_z,
	output logic signed [cpt_pkg::SEP_W-1:0]   separation,
	output logic [cpt_pkg::FIELD_W-1:0]        closest_xyz
);
	import cpt_pkg::*;

	localparam int DW     = COORD_BITS + 1;
	localparam int M_W    = 2 * COORD_BITS + 4;
	localparam int SIDE_W = 4 + 4 * DW + FIELD_W;

	// The pipeline never holds off a beat.
	assign busy = 1'b0;

	logic               f_valid;
	cpt_ctl_t           f_ctl;
	logic [M_W-1:0]     f_msq;
	logic [3*DW-1:0]    f_norm;
	logic [DW-1:0]      f_gap;
	logic [FIELD_W-1:0] f_clo;

	cpt_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start & ~busy),
		.func       (func),
		.a_low_xyz  (a_low_xyz),
		.a_high_xyz (a_high_xyz),
		.b_low_xyz  (b_low_xyz),
		.b_high_xyz (b_high_xyz),
		.a_radius   (a_radius),
		.b_radius   (b_radius),
		.out_valid  (f_valid),
		.out_ctl    (f_ctl),
		.out_msq    (f_msq),
		.out_norm   (f_norm),
		.out_gap    (f_gap),
		.out_closest(f_clo)
	);

	logic              r_valid;
	logic [M_W/2-1:0]  r_root;
	logic [SIDE_W-1:0] r_side;

	cpt_isqrt #(
		.RAD_W (M_W),
		.SIDE_W(SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.rad      (f_msq),
		.side_in  ({f_ctl, f_norm, f_gap, f_clo}),
		.out_valid(r_valid),
		.root     (r_root),
		.side_out (r_side)
	);

	// Unpack the side data that traveled with the root.
	cpt_ctl_t             s_ctl;
	logic [3*DW-1:0]      s_norm;
	logic signed [DW-1:0] s_gap;
	logic [FIELD_W-1:0]   s_clo;

	assign {s_ctl, s_norm, s_gap, s_clo} = r_side;

	// Saturate normals and separation to their field ranges.
	logic signed [NORM_W-1:0] nsat [3];
	logic signed [SEP_W-1:0]  sep_n;

	always_comb begin
		logic signed [31:0] n32, s32;
		for (int i = 0; i < 3; i++) begin
			n32 = 32'($signed(s_norm[i*DW +: DW]));
			if (n32 < NORM_LO) begin
				nsat[i] = NORM_W'(NORM_LO);
			end else if (n32 > NORM_HI) begin
				nsat[i] = NORM_W'(NORM_HI);
			end else begin
				nsat[i] = NORM_W'(n32);
			end
		end
		if (s_ctl.func == FUNC_BOX_BOX) begin
			s32 = 32'(s_gap);
		end else if (s_ctl.func == FUNC_SPH_SPH || s_ctl.func == FUNC_BOX_SPH) begin
			s32 = $signed(32'(r_root));
		end else begin
			s32 = '0;
		end
		if (s32 < SEP_LO) begin
			sep_n = SEP_W'(SEP_LO);
		end else if (s32 > SEP_HI) begin
			sep_n = SEP_W'(SEP_HI);
		end else begin
			sep_n = SEP_W'(s32);
		end
	end

	// Output register.
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		contact_class <= s_ctl.cls;
		normal_x      <= nsat[0];
		normal_y      <= nsat[1];
		normal_z      <= nsat[2];
		separation    <= sep_n;
		closest_xyz   <= s_clo;
	end

	assign done = done_q;

	// A containing pair never reports a contact normal.
	a_contains_no_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && contact_class == CLS_CONTAINS)
			|-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("contains result carries a nonzero normal");

	// Only the three defined classes leave the block.
	a_class_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (contact_class == CLS_OUTSIDE || contact_class == CLS_INTERSECTS
			|| contact_class == CLS_CONTAINS))
		else $error("undefined contact class on a result beat");

endmodule
`default_nettype wire
